FILE: hdl/carved_row_gap_fill_render_unit_defines.svh
// Assertion macros shared by the gap-fill renderer modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef CARVED_ROW_GAP_FILL_RENDER_UNIT_DEFINES_SVH
`define CARVED_ROW_GAP_FILL_RENDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CRGF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crgf check failed");

// Next-cycle implication, checked out of reset.
`define CRGF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crgf check failed");

`endif

FILE: hdl/crgf_pkg.sv
// Types and constants for the carved-row gap-fill renderer.
// No dependencies; used by crgf_div and the top level.
`default_nettype none

package crgf_pkg;

    localparam int CHAN_W    = 8;
    localparam int GAP_W     = 6;
    localparam int NUM_W     = 14;   // |diff| * k, 255 * 62 fits
    localparam int DEN_W     = 6;    // gap + 1, at most 63
    localparam int CFG_W     = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [GAP_W-1:0]  MAX_GAP      = 6'd62;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILL_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE   = 1'b1;

    // Fill modes (code 3 behaves as copy)
    localparam logic [CFG_W-1:0] MODE_COPY = 2'd0;
    localparam logic [CFG_W-1:0] MODE_AVG  = 2'd1;
    localparam logic [CFG_W-1:0] MODE_GRAD = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [GAP_W-1:0]  gap_after;
        logic              row_end;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              row_done;
        logic              run_last;
    } render_t;

endpackage

`default_nettype wire

FILE: hdl/crgf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on crgf_pkg and the assertion macro header.
`default_nettype none
`include "carved_row_gap_fill_render_unit_defines.svh"

module crgf_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [crgf_pkg::NUM_W-1:0] dividend,
    input  wire logic [crgf_pkg::DEN_W-1:0] divisor,
    output logic                            busy,
    output logic                            done,
    output logic [crgf_pkg::NUM_W-1:0]      quotient
);
    import crgf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};

        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = '0;
            den_next  = divisor;
            quo_next  = dividend;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // Checks
    `CRGF_ASSERT_IMPL(a_no_restart, clk, rst_n, start, !busy_reg && !done_reg)
    `CRGF_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `CRGF_ASSERT_NEXT(a_last_step, clk, rst_n, busy_reg && cnt_reg == CNT_W'(1), done_reg)

endmodule

`default_nettype wire

FILE: hdl/carved_row_gap_fill_render_unit.sv
// Gap-fill row renderer for carved image rows: sequencer, hold register,
// output register. Depends on crgf_pkg, crgf_div and the macro header.
//
// Pixels of a row enter one at a time; each is held until its right
// neighbor arrives, then the held pixel and (with fill on) one fill pixel
// per removed position come out, followed by the row-end pixel on a row end.
// One item is worked at a time: pixel_ready is high only while idle. In
// gradient mode each fill pixel runs three 14-step divisions through one
// shared restoring divider, one after another. Stalls on render_ready hold
// the sequencer in the state that waits to emit.
`default_nettype none
`include "carved_row_gap_fill_render_unit_defines.svh"

module carved_row_gap_fill_render_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [crgf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crgf_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           pixel_valid,
    output logic                                pixel_ready,
    input  wire crgf_pkg::pixel_t               pixel,
    output logic                                render_valid,
    input  wire logic                           render_ready,
    output crgf_pkg::render_t                   render
);
    import crgf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HELD,
        S_FILL,
        S_DIV_START,
        S_DIV_WAIT,
        S_FILL_EMIT,
        S_END,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    pixel_t            cur_reg, cur_next;
    pixel_t            held_reg, held_next;
    logic              held_valid_reg, held_valid_next;
    logic [GAP_W-1:0]  k_reg, k_next;
    logic [1:0]        ch_reg, ch_next;
    logic [NUM_W-1:0]  acc_reg [3];
    logic [NUM_W-1:0]  acc_next [3];
    logic [CHAN_W-1:0] grad_reg [3];
    logic [CHAN_W-1:0] grad_next [3];
    logic              out_valid_reg, out_valid_next;
    render_t           out_reg, out_next;
    logic              fill_enable_reg, fill_enable_next;
    logic [CFG_W-1:0]  fill_mode_reg, fill_mode_next;

    logic [CHAN_W-1:0] left [3];
    logic [CHAN_W-1:0] right [3];
    logic [CHAN_W-1:0] absd [3];
    logic              neg [3];
    logic [CHAN_W:0]   sum [3];
    logic [GAP_W-1:0]  gap_sat;
    logic              fill_go;
    logic              last_fill;
    logic              slot_free;
    render_t           fill_px;
    render_t           held_px;
    render_t           end_px;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;
    logic [CHAN_W-1:0] quo8;

    // Shared divider for the gradient terms
    crgf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg[ch_reg]),
        .divisor  (DEN_W'(held_reg.gap_after) + 1'b1),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo8 = div_quo[CHAN_W-1:0];

    // Per-channel neighbor terms
    always_comb
    begin
        left[0]  = held_reg.red;
        left[1]  = held_reg.green;
        left[2]  = held_reg.blue;
        right[0] = cur_reg.red;
        right[1] = cur_reg.green;
        right[2] = cur_reg.blue;
        for (int i = 0; i < 3; i++)
        begin
            neg[i]  = (right[i] < left[i]);
            absd[i] = neg[i] ? (left[i] - right[i]) : (right[i] - left[i]);
            sum[i]  = {1'b0, left[i]} + {1'b0, right[i]};
        end
    end

    assign gap_sat   = (pixel.gap_after > MAX_GAP) ? MAX_GAP : pixel.gap_after;
    assign fill_go   = fill_enable_reg && (held_reg.gap_after != '0);
    assign last_fill = (k_reg == held_reg.gap_after);
    assign slot_free = !out_valid_reg || render_ready;

    // Candidate results
    always_comb
    begin
        held_px = '{held_reg.red, held_reg.green, held_reg.blue, held_reg.alpha,
                    1'b0, !fill_go && !cur_reg.row_end};
        end_px  = '{cur_reg.red, cur_reg.green, cur_reg.blue, cur_reg.alpha,
                    1'b1, 1'b1};
        case (fill_mode_reg)
            MODE_AVG:
            begin
                fill_px = '{sum[0][CHAN_W:1], sum[1][CHAN_W:1], sum[2][CHAN_W:1],
                            ALPHA_OPAQUE, 1'b0, 1'b0};
            end
            MODE_GRAD:
            begin
                fill_px = '{grad_reg[0], grad_reg[1], grad_reg[2],
                            ALPHA_OPAQUE, 1'b0, 1'b0};
            end
            default:
            begin
                fill_px = '{held_reg.red, held_reg.green, held_reg.blue,
                            held_reg.alpha, 1'b0, 1'b0};
            end
        endcase
        fill_px.run_last = last_fill && !cur_reg.row_end;
    end

    // Sequencer, hold, output register and configuration
    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        held_next        = held_reg;
        held_valid_next  = held_valid_reg;
        k_next           = k_reg;
        ch_next          = ch_reg;
        acc_next         = acc_reg;
        grad_next        = grad_reg;
        out_valid_next   = out_valid_reg && !render_ready;
        out_next         = out_reg;
        fill_enable_next = fill_enable_reg;
        fill_mode_next   = fill_mode_reg;
        div_start        = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FILL_ENABLE: fill_enable_next = cfg_data[0];
                REG_FILL_MODE:   fill_mode_next   = cfg_data;
                default:         fill_mode_next   = fill_mode_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    cur_next           = pixel;
                    cur_next.gap_after = gap_sat;
                    if (held_valid_reg)
                        state_next = S_HELD;
                    else if (pixel.row_end)
                        state_next = S_END;
                    else
                        state_next = S_FINISH;
                end
            end
            S_HELD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = held_px;
                    k_next         = GAP_W'(1);
                    for (int i = 0; i < 3; i++)
                        acc_next[i] = NUM_W'(absd[i]);
                    if (fill_go)
                        state_next = S_FILL;
                    else if (cur_reg.row_end)
                        state_next = S_END;
                    else
                        state_next = S_FINISH;
                end
            end
            S_FILL:
            begin
                ch_next    = 2'd0;
                state_next = (fill_mode_reg == MODE_GRAD) ? S_DIV_START : S_FILL_EMIT;
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    grad_next[ch_reg] = neg[ch_reg] ? (left[ch_reg] - quo8)
                                                    : (left[ch_reg] + quo8);
                    if (ch_reg == 2'd2)
                    begin
                        state_next = S_FILL_EMIT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_DIV_START;
                    end
                end
            end
            S_FILL_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = fill_px;
                    if (last_fill)
                    begin
                        state_next = cur_reg.row_end ? S_END : S_FINISH;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        for (int i = 0; i < 3; i++)
                            acc_next[i] = acc_reg[i] + NUM_W'(absd[i]);
                        state_next = S_FILL;
                    end
                end
            end
            S_END:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = end_px;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                held_next       = cur_reg.row_end ? '0 : cur_reg;
                held_valid_next = !cur_reg.row_end;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cur_reg         <= '0;
            held_reg        <= '0;
            held_valid_reg  <= 1'b0;
            k_reg           <= '0;
            ch_reg          <= '0;
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i]  <= '0;
                grad_reg[i] <= '0;
            end
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            fill_enable_reg <= 1'b0;
            fill_mode_reg   <= MODE_COPY;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            held_reg        <= held_next;
            held_valid_reg  <= held_valid_next;
            k_reg           <= k_next;
            ch_reg          <= ch_next;
            acc_reg         <= acc_next;
            grad_reg        <= grad_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
            fill_enable_reg <= fill_enable_next;
            fill_mode_reg   <= fill_mode_next;
        end
    end

    assign pixel_ready  = (state_reg == S_IDLE);
    assign render_valid = out_valid_reg;
    assign render       = out_reg;

    // Checks
    `CRGF_ASSERT_IMPL(a_ready_div_idle, clk, rst_n, pixel_ready, !div_busy)
    `CRGF_ASSERT_IMPL(a_done_is_last, clk, rst_n, render_valid && render.row_done, render.run_last)
    `CRGF_ASSERT_NEXT(a_end_clears_hold, clk, rst_n, state_reg == S_FINISH && cur_reg.row_end, !held_valid_reg)

endmodule

`default_nettype wire

FILE: tb/tb_carved_row_gap_fill_render_unit.sv
// Self-checking testbench for carved_row_gap_fill_render_unit: directed and random rows.
// A scoreboard class predicts every rendered pixel; depends on crgf_pkg and the RTL.
`timescale 1ns / 1ps

// Predicts rendered pixels from accepted input items and checks each result in order
class render_scoreboard;
    bit                          fill_on = 1'b0;
    logic [crgf_pkg::CFG_W-1:0]  fill_mode = '0;
    crgf_pkg::pixel_t            held_px = '0;
    logic [crgf_pkg::GAP_W-1:0]  held_gap = '0;
    bit                          held_valid = 1'b0;
    crgf_pkg::render_t           due_q[$];
    int                          errors = 0;

    function void write_reg(logic [crgf_pkg::CFG_IDX_W-1:0] idx,
                            logic [crgf_pkg::CFG_W-1:0] data);
        case (idx)
            crgf_pkg::REG_FILL_ENABLE: fill_on = data[0];
            crgf_pkg::REG_FILL_MODE:   fill_mode = data;
            default: ;
        endcase
    endfunction

    function crgf_pkg::render_t make_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] a, logic done);
        crgf_pkg::render_t px;
        px.out_red   = r;
        px.out_green = g;
        px.out_blue  = b;
        px.out_alpha = a;
        px.row_done  = done;
        px.run_last  = 1'b0;
        return px;
    endfunction

    // left + (right - left) * k / (gap + 1), division truncated toward zero
    function logic [7:0] ramp_channel(logic [7:0] left, logic [7:0] right, int k, int gap);
        int l;
        int r;
        int v;
        l = left;
        r = right;
        v = l + ((r - l) * k) / (gap + 1);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function logic [7:0] mean_channel(logic [7:0] left, logic [7:0] right);
        int s;
        s = (int'(left) + int'(right)) >> 1;
        return s[7:0];
    endfunction

    function void note_pixel(crgf_pkg::pixel_t p);
        logic [crgf_pkg::GAP_W-1:0] gap;
        crgf_pkg::render_t          px;
        int                         first;
        first = due_q.size();
        gap = (p.gap_after > crgf_pkg::MAX_GAP) ? crgf_pkg::MAX_GAP : p.gap_after;

        // held pixel, then its fill run
        if (held_valid) begin
            due_q.push_back(make_px(held_px.red, held_px.green, held_px.blue,
                                    held_px.alpha, 1'b0));
            if (fill_on) begin
                for (int k = 1; k <= held_gap; k++) begin
                    case (fill_mode)
                        crgf_pkg::MODE_AVG:
                            px = make_px(mean_channel(held_px.red, p.red),
                                         mean_channel(held_px.green, p.green),
                                         mean_channel(held_px.blue, p.blue),
                                         crgf_pkg::ALPHA_OPAQUE, 1'b0);
                        crgf_pkg::MODE_GRAD:
                            px = make_px(ramp_channel(held_px.red, p.red, k, held_gap),
                                         ramp_channel(held_px.green, p.green, k, held_gap),
                                         ramp_channel(held_px.blue, p.blue, k, held_gap),
                                         crgf_pkg::ALPHA_OPAQUE, 1'b0);
                        default:   // copy, spare code included
                            px = make_px(held_px.red, held_px.green, held_px.blue,
                                         held_px.alpha, 1'b0);
                    endcase
                    due_q.push_back(px);
                end
            end
        end

        // row end flushes; otherwise the new pixel is held
        if (p.row_end) begin
            due_q.push_back(make_px(p.red, p.green, p.blue, p.alpha, 1'b1));
            held_px    = '0;
            held_gap   = '0;
            held_valid = 1'b0;
        end else begin
            held_px    = p;
            held_gap   = gap;
            held_valid = 1'b1;
        end

        if (due_q.size() > first) begin
            px = due_q.pop_back();
            px.run_last = 1'b1;
            due_q.push_back(px);
        end
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_render(crgf_pkg::render_t got);
        crgf_pkg::render_t want;
        if (due_q.size() == 0) begin
            $display("%0t ns: unexpected pixel, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = due_q.pop_front();
        check_field("out_red",   want.out_red,   got.out_red);
        check_field("out_green", want.out_green, got.out_green);
        check_field("out_blue",  want.out_blue,  got.out_blue);
        check_field("out_alpha", want.out_alpha, got.out_alpha);
        check_field("row_done",  want.row_done,  got.row_done);
        check_field("run_last",  want.run_last,  got.run_last);
    endfunction

    function int pending();
        return due_q.size();
    endfunction
endclass

module tb_carved_row_gap_fill_render_unit;
    import crgf_pkg::*;

    // spare mode code, acts as copy
    localparam logic [CFG_W-1:0] MODE_SPARE = 2'd3;
    localparam int               SETTLE_CYCLES = 60;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_ready;
    pixel_t               pixel = '0;
    logic                 render_valid;
    logic                 render_ready = 1'b0;
    render_t              render;

    bit                   idle_on = 1'b1;
    render_scoreboard     sb;

    carved_row_gap_fill_render_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .render_valid (render_valid),
        .render_ready (render_ready),
        .render       (render)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: check accepted pixels, stall at random while idling is on
    always @(posedge clk)
    begin
        if (render_valid && render_ready)
            sb.check_render(render);
        render_ready <= !idle_on || ($urandom_range(99) >= 35);
    end

    function automatic pixel_t pixel_of(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] a, logic [GAP_W-1:0] gap, logic last);
        pixel_t p;
        p.red       = r;
        p.green     = g;
        p.blue      = b;
        p.alpha     = a;
        p.gap_after = gap;
        p.row_end   = last;
        return p;
    endfunction

    // Mostly short gaps; now and then a long one, up to the saturating code
    function automatic logic [GAP_W-1:0] rand_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return GAP_W'($urandom_range(4));
        if (pick < 85) return GAP_W'($urandom_range(15, 5));
        if (pick < 95) return GAP_W'($urandom_range(40, 16));
        return GAP_W'($urandom_range(63, 41));
    endfunction

    task automatic send_pixel(input pixel_t p);
        if (idle_on)
            while ($urandom_range(99) < 35)
            begin
                pixel_valid <= 1'b0;
                @(posedge clk);
            end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do @(posedge clk); while (!pixel_ready);
        sb.note_pixel(p);
    endtask

    // Drain all expected pixels, then give the block time to go idle
    task automatic settle();
        pixel_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_fill(input logic en, input logic [CFG_W-1:0] mode);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FILL_ENABLE;
        cfg_data  <= {{(CFG_W-1){1'b0}}, en};
        @(posedge clk);
        sb.write_reg(REG_FILL_ENABLE, {{(CFG_W-1){1'b0}}, en});
        cfg_index <= REG_FILL_MODE;
        cfg_data  <= mode;
        @(posedge clk);
        sb.write_reg(REG_FILL_MODE, mode);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random rows of random length; the phase may stop mid-row
    task automatic run_rows(input int count);
        logic last;
        for (int i = 0; i < count; i++)
        begin
            last = ($urandom_range(4) == 0) || (i == count - 1 && $urandom_range(1) == 1);
            send_pixel(pixel_of(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                rand_gap(), last));
        end
    endtask

    initial
    begin
        logic             en_seq[6];
        logic [CFG_W-1:0] mode_seq[6];
        sb = new();
        en_seq   = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        mode_seq = '{MODE_GRAD, MODE_AVG, MODE_COPY, MODE_GRAD, MODE_SPARE, MODE_GRAD};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Gradient: row end with nothing held, saturated gap, full-range ramps
        program_fill(1'b1, MODE_GRAD);
        send_pixel(pixel_of(8'hFF, 8'h00, 8'h80, 8'hFF, 6'd63, 1'b1));
        send_pixel(pixel_of(8'h00, 8'hFF, 8'h00, 8'h12, 6'd63, 1'b0));
        send_pixel(pixel_of(8'hFF, 8'h00, 8'hFF, 8'hFF, 6'd1, 1'b0));
        send_pixel(pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 1'b1));
        settle();

        // Average with odd sums
        program_fill(1'b1, MODE_AVG);
        send_pixel(pixel_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd3, 1'b0));
        send_pixel(pixel_of(8'hFE, 8'h01, 8'h00, 8'h07, 6'd0, 1'b0));
        send_pixel(pixel_of(8'h03, 8'h02, 8'h01, 8'h00, 6'd2, 1'b1));
        settle();

        // Copy, alternating gap bits
        program_fill(1'b1, MODE_COPY);
        send_pixel(pixel_of(8'h0C, 8'h22, 8'h38, 8'h4E, 6'd5, 1'b0));
        send_pixel(pixel_of(8'hAA, 8'h55, 8'hAA, 8'h55, 6'd42, 1'b0));
        send_pixel(pixel_of(8'h55, 8'hAA, 8'h55, 8'hAA, 6'd21, 1'b1));
        settle();

        // Spare mode code falls back to copy
        program_fill(1'b1, MODE_SPARE);
        send_pixel(pixel_of(8'h01, 8'h02, 8'h03, 8'h04, 6'd4, 1'b0));
        send_pixel(pixel_of(8'h05, 8'h06, 8'h07, 8'h08, 6'd0, 1'b1));
        settle();

        // Filling off: mode ignored, no fill pixels
        program_fill(1'b0, MODE_GRAD);
        send_pixel(pixel_of(8'h09, 8'h09, 8'h09, 8'h09, 6'd10, 1'b0));
        send_pixel(pixel_of(8'hC8, 8'h64, 8'h32, 8'h19, 6'd62, 1'b0));
        send_pixel(pixel_of(8'h01, 8'h01, 8'h01, 8'h01, 6'd7, 1'b1));
        settle();

        // Random phases; the third runs with no idling on either side
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_on = (ph != 2);
            program_fill(en_seq[ph], (ph == 3) ? CFG_W'($urandom_range(3)) : mode_seq[ph]);
            run_rows(19);
            settle();
        end

        if (sb.errors == 0)
            $display("carved_row_gap_fill_render_unit verification clean");
        else
            $display("carved_row_gap_fill_render_unit verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #60_000_000;
        $display("carved_row_gap_fill_render_unit verification failed");
        $finish;
    end
endmodule
